// File: sv/tfmh_pkg.sv
// Package: shared constants, types and controller state encoding for the top-k heap.
package tfmh_pkg;
	localparam int HeapSlots = 64;
	localparam int KeyBits = 32;
	localparam int SlotBits = $clog2(HeapSlots);
	localparam int CountBits = 32;
	localparam logic [CountBits-1:0] CountMax = '1;

	typedef logic [SlotBits-1:0] slot_t;
	typedef logic [KeyBits-1:0] key_t;
	typedef logic [CountBits-1:0] count_t;

	typedef enum logic [0:0] {
		OP_INSERT = 1'b0,
		OP_READ   = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIND_RD,
		ST_FIND_CMP,
		ST_READ_RD,
		ST_UP_RD,
		ST_UP_CMP,
		ST_DN_RDL,
		ST_DN_RDR,
		ST_DN_RDP,
		ST_DN_CMP,
		ST_SWAP,
		ST_RES_RD,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic       load;      // capture input transaction
		logic       scan_rst;  // start key search at slot 1
		logic       scan_rd;   // read slot at scan pointer
		logic       scan_inc;
		logic       hit_write; // write incremented count at found slot
		logic       new_write; // append new key at occupancy+1
		logic       root_write;
		logic       up_rd;     // read cur and parent
		logic       up_move;
		logic       dn_rdl;
		logic       dn_rdr;
		logic       dn_rdp;
		logic       dn_pick;
		logic       swap_a;    // write first half of swap
		logic       swap_b;
		logic       res_rd;    // read result slot
		logic       pos_rd;    // read requested slot
		logic       finish;    // emit result
		logic       empty_res; // result for ignored key
	} tfmh_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_read;
		logic key_zero;
		logic scan_done;   // scan pointer beyond occupancy
		logic scan_match;
		logic found;
		logic full;
		logic up_go;       // cur > 1 and cur < parent
		logic has_right;
		logic has_left;
		logic dn_go;       // smaller child strictly less
		logic swap_dn;     // swap is part of a downward sift
	} tfmh_stat_t;
endpackage

// File: sv/topk_frequency_min_heap_top.sv
// Top-k frequency min-heap: one result strobe per command; busy while working.
// A transaction is accepted at a clock edge with start high and busy low. Busy then stays
// high until the result is ready; done pulses for one cycle, in the first cycle with busy
// low, and the entry ports then hold the result until the next one is emitted; the receiver
// cannot stall. A new transaction may be accepted in that same cycle. An ignored key passes
// through the find-read and done states, a read through find-read, read and done. An insert
// first scans one heap slot per cycle, then appends a new key and sifts it up, replaces the
// root key on a full heap, or increments a held key's count and sifts it down.
module topk_frequency_min_heap_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	output logic                 done,
	input  logic                 opcode,
	input  tfmh_pkg::key_t       item_key,
	input  tfmh_pkg::slot_t      read_position,
	output tfmh_pkg::key_t       entry_key,
	output tfmh_pkg::count_t     entry_count,
	output tfmh_pkg::slot_t      entry_slot,
	output logic                 entry_valid,
	output tfmh_pkg::slot_t      fill_count
);
	tfmh_pkg::tfmh_cmd_t  cmd;
	tfmh_pkg::tfmh_stat_t stat;

	tfmh_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.stat(stat), .cmd(cmd)
	);

	tfmh_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.op_in(opcode), .key_in(item_key), .pos_in(read_position),
		.res_key(entry_key), .res_count(entry_count), .res_slot(entry_slot),
		.res_valid(entry_valid), .res_fill(fill_count)
	);
endmodule

// File: sv/tfmh_ram.sv
// Generic single-port RAM with registered read.
module tfmh_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// File: sv/tfmh_dp.sv
// Datapath: key and count memories, sift pointers, occupancy and result registers.
module tfmh_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  tfmh_pkg::tfmh_cmd_t cmd,
	output tfmh_pkg::tfmh_stat_t stat,
	input  logic                op_in,
	input  tfmh_pkg::key_t      key_in,
	input  tfmh_pkg::slot_t     pos_in,
	output tfmh_pkg::key_t      res_key,
	output tfmh_pkg::count_t    res_count,
	output tfmh_pkg::slot_t     res_slot,
	output logic                res_valid,
	output tfmh_pkg::slot_t     res_fill
);
	localparam int SB = tfmh_pkg::SlotBits;
	localparam int HS = tfmh_pkg::HeapSlots;

	logic                op_q;
	tfmh_pkg::key_t      key_q;
	tfmh_pkg::slot_t     pos_q;
	tfmh_pkg::slot_t     occ_q;
	logic [SB:0]         scan_q;   // one extra bit to pass occupancy
	tfmh_pkg::slot_t     cur_q;
	tfmh_pkg::slot_t     oth_q;    // swap partner
	tfmh_pkg::key_t      ka_q, kb_q;
	tfmh_pkg::count_t    ca_q, cb_q, cl_q;
	logic                found_q;
	logic                dn_q;
	logic                rd_parent_q;

	logic                we;
	logic                we_cnt;
	tfmh_pkg::slot_t     addr;
	tfmh_pkg::key_t      wkey;
	tfmh_pkg::count_t    wcnt;
	tfmh_pkg::key_t      rkey;
	tfmh_pkg::count_t    rcnt;

	logic [SB:0] left_w, right_w;
	tfmh_pkg::slot_t parent;

	assign parent  = cur_q >> 1;
	assign left_w  = {cur_q, 1'b0};
	assign right_w = {cur_q, 1'b1};

	// root replacement keeps the root count
	assign we_cnt = we && !cmd.root_write;

	tfmh_ram #(.Width(tfmh_pkg::KeyBits), .Depth(HS)) u_keys (
		.clk(clk), .we(we), .addr(addr), .wdata(wkey), .rdata(rkey)
	);
	tfmh_ram #(.Width(tfmh_pkg::CountBits), .Depth(HS)) u_cnts (
		.clk(clk), .we(we_cnt), .addr(addr), .wdata(wcnt), .rdata(rcnt)
	);

	always_comb begin
		we   = 1'b0;
		addr = cur_q;
		wkey = ka_q;
		wcnt = ca_q;
		if (cmd.scan_rd) begin
			// compare runs one slot behind the read address
			addr = cmd.scan_inc ? scan_q[SB-1:0] + 1'b1 : scan_q[SB-1:0];
		end else if (cmd.hit_write) begin
			we   = 1'b1;
			addr = cur_q;
			wkey = key_q;
			wcnt = (ca_q == tfmh_pkg::CountMax) ? ca_q : ca_q + 1'b1;
		end else if (cmd.new_write) begin
			we   = 1'b1;
			addr = occ_q + 1'b1;
			wkey = key_q;
			wcnt = tfmh_pkg::count_t'(1);
		end else if (cmd.root_write) begin
			we   = 1'b1;
			addr = tfmh_pkg::slot_t'(1);
			wkey = key_q;
		end else if (cmd.up_rd) begin
			addr = rd_parent_q ? parent : cur_q;
		end else if (cmd.dn_rdl) begin
			addr = left_w[SB-1:0];
		end else if (cmd.dn_rdr) begin
			addr = right_w[SB-1:0];
		end else if (cmd.dn_rdp) begin
			addr = cur_q;
		end else if (cmd.swap_a) begin
			we   = 1'b1;
			addr = cur_q;
			wkey = kb_q;
			wcnt = cb_q;
		end else if (cmd.swap_b) begin
			we   = 1'b1;
			addr = oth_q;
			wkey = ka_q;
			wcnt = ca_q;
		end else if (cmd.res_rd) begin
			addr = cur_q;
		end else if (cmd.pos_rd) begin
			addr = pos_q;
		end
	end

	assign stat.is_read    = op_q == tfmh_pkg::OP_READ;
	assign stat.key_zero   = key_q == '0;
	assign stat.scan_done  = scan_q > {1'b0, occ_q};
	assign stat.scan_match = rkey == key_q;
	assign stat.found      = found_q;
	assign stat.full       = {1'b0, occ_q} >= (SB+1)'(HS - 1);
	assign stat.up_go      = (cur_q > tfmh_pkg::slot_t'(1)) && (ca_q < rcnt);
	assign stat.has_left   = left_w <= {1'b0, occ_q};
	assign stat.has_right  = right_w <= {1'b0, occ_q};
	assign stat.dn_go      = cb_q < rcnt;
	assign stat.swap_dn    = dn_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			found_q <= 1'b0;
			dn_q    <= 1'b0;
			rd_parent_q <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			if (cmd.load) begin
				found_q <= 1'b0;
			end
			if (cmd.scan_inc && stat.scan_match) begin
				found_q <= 1'b1;
			end
			if (cmd.new_write) begin
				occ_q <= occ_q + 1'b1;
			end
			if (cmd.up_rd) begin
				rd_parent_q <= !rd_parent_q;
			end
			if (cmd.new_write) begin
				dn_q <= 1'b0;
				rd_parent_q <= 1'b0;
			end
			if (cmd.hit_write) begin
				dn_q <= 1'b1;
			end
			if (cmd.finish) begin
				res_valid <= (op_q == tfmh_pkg::OP_READ) ?
					(pos_q != '0 && pos_q <= occ_q) : !cmd.empty_res;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op_in;
			key_q <= key_in;
			pos_q <= pos_in;
		end
		if (cmd.scan_rst) begin
			scan_q <= (SB+1)'(1);
		end
		if (cmd.scan_inc) begin
			if (stat.scan_match && !found_q) begin
				cur_q <= scan_q[SB-1:0];
				ca_q  <= rcnt;
			end
			scan_q <= scan_q + 1'b1;
		end
		if (cmd.new_write) begin
			cur_q <= occ_q + 1'b1;
		end
		if (cmd.root_write) begin
			cur_q <= tfmh_pkg::slot_t'(1);
		end
		if (cmd.up_rd && rd_parent_q) begin
			ka_q <= rkey;
			ca_q <= rcnt;
		end
		if (cmd.up_move) begin
			kb_q  <= rkey;
			cb_q  <= rcnt;
			oth_q <= parent;
		end
		if (cmd.dn_rdr) begin
			kb_q  <= rkey;
			cb_q  <= rcnt;
			cl_q  <= rcnt;
			oth_q <= left_w[SB-1:0];
		end
		if (cmd.dn_rdp) begin
			if (stat.has_right && rcnt < cl_q) begin
				kb_q  <= rkey;
				cb_q  <= rcnt;
				oth_q <= right_w[SB-1:0];
			end
		end
		if (cmd.dn_pick) begin
			ka_q <= rkey;
			ca_q <= rcnt;
		end
		if (cmd.swap_b) begin
			cur_q <= oth_q;
		end
		if (cmd.finish) begin
			res_fill <= occ_q;
			if (op_q == tfmh_pkg::OP_READ) begin
				res_slot <= pos_q;
				if (pos_q != '0 && pos_q <= occ_q) begin
					res_key   <= rkey;
					res_count <= rcnt;
				end else begin
					res_key   <= '0;
					res_count <= '0;
				end
			end else if (cmd.empty_res) begin
				res_key   <= '0;
				res_count <= '0;
				res_slot  <= '0;
			end else begin
				res_key   <= rkey;
				res_count <= rcnt;
				res_slot  <= cur_q;
			end
		end
	end
endmodule

// File: sv/tfmh_ctrl.sv
// Controller: sequences key search, insert and sift steps over the memory port.
module tfmh_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	output logic                 done,
	input  tfmh_pkg::tfmh_stat_t stat,
	output tfmh_pkg::tfmh_cmd_t  cmd
);
	tfmh_pkg::state_t state_q, state_d;
	logic up_half_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tfmh_pkg::ST_IDLE;
			up_half_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == tfmh_pkg::ST_UP_RD || state_q == tfmh_pkg::ST_SWAP) begin
				up_half_q <= !up_half_q;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tfmh_pkg::ST_IDLE: begin
				if (start) begin
					state_d = tfmh_pkg::ST_FIND_RD;
				end
			end
			tfmh_pkg::ST_FIND_RD: begin
				if (stat.is_read) begin
					state_d = tfmh_pkg::ST_READ_RD;
				end else if (stat.key_zero) begin
					state_d = tfmh_pkg::ST_DONE;
				end else if (stat.scan_done) begin
					state_d = tfmh_pkg::ST_FIND_CMP;
				end else begin
					state_d = tfmh_pkg::ST_FIND_CMP;
				end
			end
			tfmh_pkg::ST_FIND_CMP: begin
				if (stat.found) begin
					state_d = tfmh_pkg::ST_DN_RDL;
				end else if (stat.scan_done) begin
					state_d = stat.full ? tfmh_pkg::ST_RES_RD : tfmh_pkg::ST_UP_RD;
				end else begin
					state_d = tfmh_pkg::ST_FIND_CMP;
				end
			end
			tfmh_pkg::ST_READ_RD: state_d = tfmh_pkg::ST_DONE;
			tfmh_pkg::ST_UP_RD: begin
				if (up_half_q) begin
					state_d = tfmh_pkg::ST_UP_CMP;
				end
			end
			tfmh_pkg::ST_UP_CMP: begin
				state_d = stat.up_go ? tfmh_pkg::ST_SWAP : tfmh_pkg::ST_RES_RD;
			end
			tfmh_pkg::ST_DN_RDL: begin
				state_d = stat.has_left ? tfmh_pkg::ST_DN_RDR : tfmh_pkg::ST_RES_RD;
			end
			tfmh_pkg::ST_DN_RDR: state_d = tfmh_pkg::ST_DN_RDP;
			tfmh_pkg::ST_DN_RDP: state_d = tfmh_pkg::ST_DN_CMP;
			tfmh_pkg::ST_DN_CMP: begin
				state_d = stat.dn_go ? tfmh_pkg::ST_SWAP : tfmh_pkg::ST_RES_RD;
			end
			tfmh_pkg::ST_SWAP: begin
				if (up_half_q) begin
					state_d = stat.swap_dn ? tfmh_pkg::ST_DN_RDL : tfmh_pkg::ST_UP_RD;
				end
			end
			tfmh_pkg::ST_RES_RD: state_d = tfmh_pkg::ST_DONE;
			tfmh_pkg::ST_DONE: state_d = tfmh_pkg::ST_IDLE;
			default: state_d = tfmh_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = state_q != tfmh_pkg::ST_IDLE;
		case (state_q)
			tfmh_pkg::ST_IDLE: begin
				cmd.load     = start;
				cmd.scan_rst = start;
			end
			tfmh_pkg::ST_FIND_RD: begin
				cmd.scan_rd = 1'b1;
			end
			tfmh_pkg::ST_FIND_CMP: begin
				if (stat.found) begin
					cmd.hit_write = 1'b1;
				end else if (stat.scan_done) begin
					cmd.new_write  = !stat.full;
					cmd.root_write = stat.full;
				end else begin
					cmd.scan_inc = 1'b1;
					cmd.scan_rd  = 1'b1;
				end
			end
			tfmh_pkg::ST_READ_RD: cmd.pos_rd = 1'b1;
			tfmh_pkg::ST_UP_RD: cmd.up_rd = 1'b1;
			tfmh_pkg::ST_UP_CMP: cmd.up_move = 1'b1;
			tfmh_pkg::ST_DN_RDL: cmd.dn_rdl = stat.has_left;
			tfmh_pkg::ST_DN_RDR: cmd.dn_rdr = 1'b1;
			tfmh_pkg::ST_DN_RDP: cmd.dn_rdp = 1'b1;
			tfmh_pkg::ST_DN_CMP: cmd.dn_pick = 1'b1;
			tfmh_pkg::ST_SWAP: begin
				cmd.swap_a = !up_half_q;
				cmd.swap_b = up_half_q;
			end
			tfmh_pkg::ST_RES_RD: cmd.res_rd = 1'b1;
			tfmh_pkg::ST_DONE: begin
				cmd.finish    = 1'b1;
				cmd.empty_res = stat.key_zero && !stat.is_read;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= state_q == tfmh_pkg::ST_DONE;
		end
	end

`ifndef NO_ASSERTIONS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done);
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy);
	a_state_known: assert property (@(posedge clk) disable iff (!arst_n) !$isunknown(state_q));
`endif
endmodule
